/* sv/mpqh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqh_pkg
// Shared constants, key table contents and seed constants of the triple
// string hash unit.
// ----------------------------------------------------------------------------
package mpqh_pkg;

	localparam int NUM_TYPES      = 3;
	localparam int KEY_W          = 32;
	localparam int BYTE_W         = 8;
	localparam int ROM_COLS       = 256;
	localparam int ROM_ROWS       = 5;
	localparam int ROM_WORDS      = ROM_ROWS * ROM_COLS;
	localparam int TABLE_SIZE_DEF = 40960;
	localparam int BUCKET_W       = 16;

	localparam logic [31:0] SEED1_INIT = 32'h7FED_7FED;
	localparam logic [31:0] SEED2_INIT = 32'hEEEE_EEEE;
	localparam logic [31:0] LCG_SEED   = 32'h0010_0001;
	localparam logic [31:0] LCG_MUL    = 32'd125;
	localparam logic [31:0] LCG_ADD    = 32'd3;
	localparam logic [31:0] LCG_MOD    = 32'h002A_AAAB;
	localparam logic [31:0] SEED2_ADD  = 32'd3;

	typedef logic [KEY_W-1:0] key_rom_t [ROM_WORDS];

	function automatic logic [31:0] lcg_next(input logic [31:0] s);
		return 32'((64'(s) * 64'(LCG_MUL) + 64'(LCG_ADD)) % 64'(LCG_MOD));
	endfunction

	function automatic key_rom_t build_key_table();
		key_rom_t    tbl;
		logic [31:0] s;
		logic [31:0] hi;
		s = LCG_SEED;
		for (int col = 0; col < ROM_COLS; col++) begin
			for (int row = 0; row < ROM_ROWS; row++) begin
				s  = lcg_next(s);
				hi = {s[15:0], 16'h0000};
				s  = lcg_next(s);
				tbl[row * ROM_COLS + col] = hi | {16'h0000, s[15:0]};
			end
		end
		return tbl;
	endfunction

	localparam key_rom_t KEY_TABLE = build_key_table();

endpackage

/* sv/mpqh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpqh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mpqh_ram #(
	parameter int WIDTH = mpqh_pkg::KEY_W,
	parameter int DEPTH = mpqh_pkg::ROM_COLS
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

/* sv/mpq_string_hash_triple_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_string_hash_triple_unit
// Byte-serial MPQ string hash, offset and both check hashes side by side,
// plus the bucket index of the offset hash.
// ----------------------------------------------------------------------------
// throughput: one key byte per cycle once the tables are filled; the seed
//   update of a byte that is not last completes in the cycle after its key
//   table read; such bytes never wait, a last byte may wait on result stages
// stages: table read, seed update, two multiplier stages for the bucket, output
// reset: seeds rearm at once; the three key table RAMs are then filled with
//   their 256 words each, during which no request is taken
module mpq_string_hash_triple_unit #(
	parameter int TABLE_SIZE = mpqh_pkg::TABLE_SIZE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,  // key_byte[7:0]
	input  logic         s_axis_tlast,  // is_last
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// offset_hash[31:0], check_hash_a[63:32], check_hash_b[95:64], bucket[111:96]
	output logic [111:0] m_axis_tdata
);

	import mpqh_pkg::*;

	localparam int          COL_W  = $clog2(ROM_COLS);
	localparam int          INIT_W = $clog2(ROM_COLS + 1);
	localparam logic [31:0] TS     = 32'(TABLE_SIZE);
	localparam logic [31:0] RECIP  = 32'(64'hFFFF_FFFF / 64'(TABLE_SIZE));

	logic [INIT_W-1:0] init_cnt_q;
	logic              init_done;

	logic              accept;
	logic [KEY_W-1:0]  tbl_word [NUM_TYPES];

	logic              v1_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	logic [31:0]       seed1_q [NUM_TYPES];
	logic [31:0]       seed2_q [NUM_TYPES];
	logic              ended_q;
	logic [31:0]       nseed1 [NUM_TYPES];
	logic [31:0]       nseed2 [NUM_TYPES];
	logic              do_upd;

	logic              v2_s2, v3_s3, v4_s4, vo_q;
	logic [31:0]       h0_s2, h1_s2, h2_s2;
	logic [31:0]       h0_s3, h1_s3, h2_s3;
	logic [31:0]       h0_s4, h1_s4, h2_s4;
	logic [63:0]       prod_s3;
	logic [31:0]       qt_s4;
	logic [31:0]       rem;
	logic [31:0]       rem_fix;
	logic [31:0]       h0_q, h1_q, h2_q;
	logic [BUCKET_W-1:0] bucket_q;

	logic ro, r4, r3, r2, r1;
	logic leave1;

	assign init_done = (init_cnt_q == INIT_W'(ROM_COLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_cnt_q <= '0;
		end else if (!init_done) begin
			init_cnt_q <= init_cnt_q + 1'b1;
		end
	end

	// ready chain from the output back to the input
	assign ro     = !vo_q || m_axis_tready;
	assign r4     = !v4_s4 || ro;
	assign r3     = !v3_s3 || r4;
	assign r2     = !v2_s2 || r3;
	assign leave1 = v1_s1 && (!last_s1 || r2);
	assign r1     = !v1_s1 || leave1;

	assign s_axis_tready = r1 && init_done;
	assign accept        = s_axis_tvalid && s_axis_tready;

	for (genvar t = 0; t < NUM_TYPES; t++) begin : g_rom
		mpqh_ram #(
			.WIDTH (KEY_W),
			.DEPTH (ROM_COLS)
		) u_ram (
			.clk     (clk),
			.wr_en   (!init_done),
			.wr_addr (init_cnt_q[COL_W-1:0]),
			.wr_data (KEY_TABLE[{3'(t), init_cnt_q[COL_W-1:0]}]),
			.rd_en   (accept),
			.rd_addr (s_axis_tdata),
			.rd_data (tbl_word[t])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (r1) begin
			v1_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// seed update
	assign do_upd = !ended_q && (byte_s1 != '0);

	always_comb begin
		for (int t = 0; t < NUM_TYPES; t++) begin
			if (do_upd) begin
				nseed1[t] = tbl_word[t] ^ (seed1_q[t] + seed2_q[t]);
				nseed2[t] = 32'(byte_s1) + nseed1[t] + seed2_q[t]
					+ {seed2_q[t][26:0], 5'b00000} + SEED2_ADD;
			end else begin
				nseed1[t] = seed1_q[t];
				nseed2[t] = seed2_q[t];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NUM_TYPES; t++) begin
				seed1_q[t] <= SEED1_INIT;
				seed2_q[t] <= SEED2_INIT;
			end
			ended_q <= 1'b0;
		end else if (leave1) begin
			if (last_s1) begin
				for (int t = 0; t < NUM_TYPES; t++) begin
					seed1_q[t] <= SEED1_INIT;
					seed2_q[t] <= SEED2_INIT;
				end
				ended_q <= 1'b0;
			end else begin
				for (int t = 0; t < NUM_TYPES; t++) begin
					seed1_q[t] <= nseed1[t];
					seed2_q[t] <= nseed2[t];
				end
				if (byte_s1 == '0) begin
					ended_q <= 1'b1;
				end
			end
		end
	end

	// result pipeline: bucket by reciprocal multiply and one correction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			vo_q  <= 1'b0;
		end else begin
			if (r2) begin
				v2_s2 <= leave1 && last_s1;
			end
			if (r3) begin
				v3_s3 <= v2_s2;
			end
			if (r4) begin
				v4_s4 <= v3_s3;
			end
			if (ro) begin
				vo_q <= v4_s4;
			end
		end
	end

	assign rem     = h0_s4 - qt_s4;
	assign rem_fix = (rem >= TS) ? (rem - TS) : rem;

	always_ff @(posedge clk) begin
		if (r2 && leave1 && last_s1) begin
			h0_s2 <= nseed1[0];
			h1_s2 <= nseed1[1];
			h2_s2 <= nseed1[2];
		end
		if (r3 && v2_s2) begin
			h0_s3   <= h0_s2;
			h1_s3   <= h1_s2;
			h2_s3   <= h2_s2;
			prod_s3 <= 64'(h0_s2) * 64'(RECIP);
		end
		if (r4 && v3_s3) begin
			h0_s4 <= h0_s3;
			h1_s4 <= h1_s3;
			h2_s4 <= h2_s3;
			qt_s4 <= 32'(prod_s3[63:32] * TS);
		end
		if (ro && v4_s4) begin
			h0_q     <= h0_s4;
			h1_q     <= h1_s4;
			h2_q     <= h2_s4;
			bucket_q <= rem_fix[BUCKET_W-1:0];
		end
	end

	assign m_axis_tvalid = vo_q;
	assign m_axis_tdata  = {bucket_q, h2_q, h1_q, h0_q};

endmodule

/* tb/mpq_string_hash_triple_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_string_hash_triple_unit_test
// Streams keys byte by byte into the triple string hash unit and checks the
// offset hash, both check hashes and the bucket of every finished key against
// a predictor that runs its own copy of the seeds and the key table, under
// phases of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module mpq_string_hash_triple_unit_test;

	import mpqh_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int TARGET_BYTES   = 1650;

	typedef struct {
		logic [7:0] key_byte;
		logic       is_last;
		int         send_gap_pct;
		int         recv_stall_pct;
		bit         wait_drain;
	} key_request_t;

	typedef struct {
		logic [31:0] offset_hash;
		logic [31:0] check_hash_a;
		logic [31:0] check_hash_b;
		logic [15:0] bucket;
	} hash_result_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;  // key_byte[7:0]
	logic         s_axis_tlast = 1'b0;   // is_last
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [111:0] m_axis_tdata;          // offset_hash, check_hash_a, check_hash_b, bucket

	key_request_t pending_requests[$];
	hash_result_t expected_hashes[$];
	logic [31:0]  key_rom [ROM_WORDS];

	logic [31:0]  first_seed [NUM_TYPES];
	logic [31:0]  second_seed [NUM_TYPES];
	bit           key_done;

	key_request_t next_request;
	int           recv_stall_pct = 0;
	int           fail_count = 0;
	int           bytes_hashed = 0;
	int           keys_finished = 0;
	int           keys_cut_by_zero = 0;
	int           hashes_checked = 0;
	int           idle_cycles = 0;

	mpq_string_hash_triple_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] lcg_advance(input logic [31:0] s);
		logic [63:0] w;
		w = 64'(s) * 64'(LCG_MUL) + 64'(LCG_ADD);
		return 32'(w % 64'(LCG_MOD));
	endfunction

	task automatic fill_key_rom();
		logic [31:0] s;
		logic [15:0] hi;
		s = LCG_SEED;
		for (int col = 0; col < ROM_COLS; col++) begin
			for (int row = 0; row < ROM_ROWS; row++) begin
				s  = lcg_advance(s);
				hi = s[15:0];
				s  = lcg_advance(s);
				key_rom[row * ROM_COLS + col] = {hi, s[15:0]};
			end
		end
	endtask

	task automatic rearm_seeds();
		for (int t = 0; t < NUM_TYPES; t++) begin
			first_seed[t]  = SEED1_INIT;
			second_seed[t] = SEED2_INIT;
		end
		key_done = 1'b0;
	endtask

	task automatic hash_key_byte(input logic [7:0] c, input logic last);
		logic [31:0]  s1;
		logic [31:0]  s2;
		hash_result_t r;
		if (!key_done) begin
			if (c == 8'h00) begin
				key_done = 1'b1;
				keys_cut_by_zero++;
			end else begin
				for (int t = 0; t < NUM_TYPES; t++) begin
					s1 = key_rom[t * ROM_COLS + int'(c)] ^ (first_seed[t] + second_seed[t]);
					s2 = 32'(c) + s1 + second_seed[t] + (second_seed[t] << 5) + SEED2_ADD;
					first_seed[t]  = s1;
					second_seed[t] = s2;
				end
			end
		end
		if (last) begin
			r.offset_hash  = first_seed[0];
			r.check_hash_a = first_seed[1];
			r.check_hash_b = first_seed[2];
			r.bucket       = 16'(first_seed[0] % 32'(TABLE_SIZE_DEF));
			expected_hashes.push_back(r);
			keys_finished++;
			rearm_seeds();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		fail_count++;
		$display("%0t: mismatch on %s: got %h, want %h", $realtime, what, got, want);
	endtask

	task automatic queue_byte(input logic [7:0] c, input logic last, input int mode,
			input bit drain);
		key_request_t q;
		q.key_byte   = c;
		q.is_last    = last;
		q.wait_drain = drain;
		case (mode)
			1: begin
				q.send_gap_pct = 55; q.recv_stall_pct = 0;
			end
			2: begin
				q.send_gap_pct = 0; q.recv_stall_pct = 55;
			end
			3: begin
				q.send_gap_pct = 22; q.recv_stall_pct = 22;
			end
			default: begin
				q.send_gap_pct = 0; q.recv_stall_pct = 0;
			end
		endcase
		pending_requests.push_back(q);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				hash_key_byte(s_axis_tdata, s_axis_tlast);
				bytes_hashed++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_requests.size() > 0
						&& !(pending_requests[0].wait_drain && expected_hashes.size() > 0)
						&& $urandom_range(99) >= pending_requests[0].send_gap_pct) begin
					next_request = pending_requests.pop_front();
					s_axis_tdata   <= next_request.key_byte;
					s_axis_tlast   <= next_request.is_last;
					s_axis_tvalid  <= 1'b1;
					recv_stall_pct <= next_request.recv_stall_pct;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_hashes.size() == 0) begin
					report_mismatch("unexpected result", m_axis_tdata[31:0], 32'h0);
				end else begin
					hashes_checked++;
					if (m_axis_tdata[31:0] !== expected_hashes[0].offset_hash)
						report_mismatch("offset_hash", m_axis_tdata[31:0],
							expected_hashes[0].offset_hash);
					if (m_axis_tdata[63:32] !== expected_hashes[0].check_hash_a)
						report_mismatch("check_hash_a", m_axis_tdata[63:32],
							expected_hashes[0].check_hash_a);
					if (m_axis_tdata[95:64] !== expected_hashes[0].check_hash_b)
						report_mismatch("check_hash_b", m_axis_tdata[95:64],
							expected_hashes[0].check_hash_b);
					if (m_axis_tdata[111:96] !== expected_hashes[0].bucket)
						report_mismatch("bucket", 32'(m_axis_tdata[111:96]),
							32'(expected_hashes[0].bucket));
					void'(expected_hashes.pop_front());
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d idle cycles", idle_cycles);
				$display("Verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int queued;
		int key_count;
		int kind;
		int len;
		int mode;
		int cut;
		bit drain;
		fill_key_rom();
		rearm_seeds();

		// directed keys
		queue_byte(8'hFF, 1'b1, 0, 1'b0);
		queue_byte(8'h01, 1'b1, 0, 1'b0);
		queue_byte(8'h00, 1'b1, 0, 1'b0);
		queue_byte(8'h80, 1'b0, 0, 1'b0);
		queue_byte(8'h7F, 1'b1, 0, 1'b0);
		queue_byte(8'h41, 1'b0, 0, 1'b1);
		queue_byte(8'h42, 1'b0, 0, 1'b0);
		queue_byte(8'h00, 1'b0, 0, 1'b0);
		queue_byte(8'hFF, 1'b0, 0, 1'b0);
		queue_byte(8'h55, 1'b1, 0, 1'b0);
		queue_byte(8'hAA, 1'b0, 0, 1'b0);
		queue_byte(8'h00, 1'b1, 0, 1'b0);
		queue_byte(8'h00, 1'b0, 0, 1'b0);
		queue_byte(8'h00, 1'b0, 0, 1'b0);
		queue_byte(8'h01, 1'b1, 0, 1'b0);
		queue_byte(8'h4D, 1'b0, 0, 1'b1);
		queue_byte(8'h50, 1'b0, 0, 1'b0);
		queue_byte(8'h51, 1'b0, 0, 1'b0);
		queue_byte(8'hFE, 1'b1, 0, 1'b0);
		queued = 19;

		// random keys, mostly well formed
		key_count = 0;
		while (queued < TARGET_BYTES) begin
			mode  = ((queued - 19) / 100) % 5;
			mode  = (mode == 4) ? 0 : mode;
			drain = (key_count % 37 == 36);
			kind  = $urandom_range(99);
			if (kind < 94 && kind >= 88) begin
				queue_byte(8'($urandom_range(255)), 1'b1, mode, drain);
				queued++;
			end else begin
				len = (kind < 94) ? $urandom_range(16, 1) : $urandom_range(40, 20);
				cut = (kind >= 70 && kind < 80) ? $urandom_range(len - 1, 0) : -1;
				for (int i = 0; i < len; i++) begin
					if (i == cut || (kind >= 80 && kind < 88 && i == len - 1))
						queue_byte(8'h00, i == len - 1, mode, drain && i == 0);
					else if (kind >= 94)
						queue_byte(8'($urandom_range(255)), i == len - 1, mode, 1'b0);
					else if (i > cut && cut >= 0)
						queue_byte(8'($urandom_range(255)), i == len - 1, mode, 1'b0);
					else
						queue_byte(8'($urandom_range(255, 1)), i == len - 1, mode,
							drain && i == 0);
				end
				queued += len;
			end
			key_count++;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do @(negedge clk);
		while (pending_requests.size() > 0 || s_axis_tvalid || expected_hashes.size() > 0);
		repeat (20) @(negedge clk);

		$display("hashed %0d key bytes into %0d keys, %0d of them cut short by a zero byte",
			bytes_hashed, keys_finished, keys_cut_by_zero);
		$display("checked %0d results across gap and stall phases, %0d mismatches",
			hashes_checked, fail_count);
		if (fail_count == 0 && expected_hashes.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
